### rtl/e2q_pkg.sv
// e2q_pkg: shared types, constants and the arctangent table for the
// euler to quaternion pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int OUT_FRAC_BITS_DEF = 14;

	// working width of the cordic datapath, q30 plus sign and headroom
	localparam int XW = 33;
	// product width of two datapath words
	localparam int PW = 2 * XW;

	localparam int ANG_W = 16;
	localparam int QW    = 16;

	localparam logic [25:0]   RAD_MUL      = 26'd37480660;
	localparam logic [29:0]   INV_GAIN     = 30'd652032874;
	localparam logic [16:0]   QUARTER_TURN = 17'd11520;
	localparam logic [16:0]   HALF_TURN    = 17'd23040;

	// one angle in flight through the rotation cells
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] z;
		logic                 cneg;
		logic                 sneg;
	} rot_t;

	typedef rot_t [2:0] rot3_t;

	// arctangent of 2^-i in q30
	function automatic logic signed [XW-1:0] atan_q30(input int i);
		logic signed [XW-1:0] r;
		case (i)
			0: r = 33'sd843314857;
			1: r = 33'sd497837829;
			2: r = 33'sd263043837;
			3: r = 33'sd133525159;
			4: r = 33'sd67021687;
			5: r = 33'sd33543516;
			6: r = 33'sd16775851;
			7: r = 33'sd8388437;
			8: r = 33'sd4194283;
			9: r = 33'sd2097149;
			default: r = (i < 31) ? (33'sd1 <<< (30 - i)) : 33'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/e2q_prep.sv
// e2q_prep: folds each angle into 0..90 degrees of half angle and scales it
// to q30 radians, loading the start vector of the rotation cells. Uses e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_prep import e2q_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [3*ANG_W-1:0]      in_data,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output rot3_t                        out_data
);

	logic  valid_q;
	rot3_t data_q;
	rot3_t data_d;

	// quadrant folding and degree to radian scaling, per axis
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [ANG_W-1:0] ang;
			logic [16:0]             mag;
			logic [13:0]             red;
			logic [39:0]             prod;
			ang = in_data[k*ANG_W +: ANG_W];
			mag = ang[ANG_W-1] ? 17'(-$signed({ang[ANG_W-1], ang}))
			                   : {1'b0, ang};
			if (mag <= QUARTER_TURN) begin
				red = mag[13:0];
				data_d[k].cneg = 1'b0;
				data_d[k].sneg = ang[ANG_W-1];
			end else if (mag <= HALF_TURN) begin
				red = 14'(HALF_TURN - mag);
				data_d[k].cneg = 1'b1;
				data_d[k].sneg = ang[ANG_W-1];
			end else begin
				red = 14'(mag - HALF_TURN);
				data_d[k].cneg = 1'b1;
				data_d[k].sneg = ~ang[ANG_W-1];
			end
			prod = 40'(red) * 40'(RAD_MUL) + 40'd128;
			data_d[k].z = $signed({1'b0, prod[39:8]});
			data_d[k].x = $signed({3'b000, INV_GAIN});
			data_d[k].y = '0;
		end
	end

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule
`default_nettype wire

### rtl/e2q_cell.sv
// e2q_cell: one cordic rotation step for all three axes, registered.
// Uses e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_cell import e2q_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  rot3_t     in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output rot3_t     out_data
);

	localparam logic signed [XW-1:0] ATAN = atan_q30(IDX);

	logic  valid_q;
	rot3_t data_q;
	rot3_t data_d;

	// rotate toward zero residual angle
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			data_d[k].cneg = in_data[k].cneg;
			data_d[k].sneg = in_data[k].sneg;
			if (!in_data[k].z[XW-1]) begin
				data_d[k].x = in_data[k].x - (in_data[k].y >>> IDX);
				data_d[k].y = in_data[k].y + (in_data[k].x >>> IDX);
				data_d[k].z = in_data[k].z - ATAN;
			end else begin
				data_d[k].x = in_data[k].x + (in_data[k].y >>> IDX);
				data_d[k].y = in_data[k].y - (in_data[k].x >>> IDX);
				data_d[k].z = in_data[k].z + ATAN;
			end
		end
	end

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule
`default_nettype wire

### rtl/e2q_combine.sv
// e2q_combine: applies the quadrant signs and forms w, x, y, z from the
// half angle sines and cosines in three registered stages. Uses e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine import e2q_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  rot3_t              in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [4*QW-1:0]    out_data
);

	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] RND = SW'(1) <<< (59 - OUT_FRAC_BITS);
	localparam int SH = 60 - OUT_FRAC_BITS;
	localparam logic signed [SW-1:0] QMAX = SW'(32767);
	localparam logic signed [SW-1:0] QMIN = -SW'(32768);

	logic v1_s1, v2_s2, v3_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [XW-1:0] c [3];
	logic signed [XW-1:0] s [3];
	logic signed [PW-1:0] pa, pb, pc, pd;

	logic signed [XW-1:0] cx_s1, sx_s1, cycz_s1, sysz_s1, cysz_s1, sycz_s1;
	logic signed [PW-1:0] p_s2 [8];
	logic [4*QW-1:0]      q_s3;
	logic [4*QW-1:0]      q_d;

	assign rdy3 = ~v3_s3 | out_ready;
	assign rdy2 = ~v2_s2 | rdy3;
	assign rdy1 = ~v1_s1 | rdy2;
	assign in_ready  = rdy1;
	assign out_valid = v3_s3;
	assign out_data  = q_s3;

	// signed cosine and sine, then the y-z pair products
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c[k] = in_data[k].cneg ? -in_data[k].x : in_data[k].x;
			s[k] = in_data[k].sneg ? -in_data[k].y : in_data[k].y;
		end
		pa = c[1] * c[2] + (PW'(1) <<< 29);
		pb = s[1] * s[2] + (PW'(1) <<< 29);
		pc = c[1] * s[2] + (PW'(1) <<< 29);
		pd = s[1] * c[2] + (PW'(1) <<< 29);
	end

	// sums, rounding and saturation
	always_comb begin
		logic signed [SW-1:0] sum [4];
		logic signed [SW-1:0] v;
		sum[0] = SW'(p_s2[0]) + SW'(p_s2[1]);
		sum[1] = SW'(p_s2[2]) - SW'(p_s2[3]);
		sum[2] = SW'(p_s2[4]) + SW'(p_s2[5]);
		sum[3] = SW'(p_s2[6]) - SW'(p_s2[7]);
		for (int k = 0; k < 4; k++) begin
			v = (sum[k] + RND) >>> SH;
			if (v > QMAX) begin
				q_d[k*QW +: QW] = 16'h7fff;
			end else if (v < QMIN) begin
				q_d[k*QW +: QW] = 16'h8000;
			end else begin
				q_d[k*QW +: QW] = v[QW-1:0];
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			cx_s1   <= c[0];
			sx_s1   <= s[0];
			cycz_s1 <= XW'(pa >>> 30);
			sysz_s1 <= XW'(pb >>> 30);
			cysz_s1 <= XW'(pc >>> 30);
			sycz_s1 <= XW'(pd >>> 30);
		end
		if (rdy2 && v1_s1) begin
			p_s2[0] <= cx_s1 * cycz_s1;
			p_s2[1] <= sx_s1 * sysz_s1;
			p_s2[2] <= sx_s1 * cycz_s1;
			p_s2[3] <= cx_s1 * sysz_s1;
			p_s2[4] <= cx_s1 * sycz_s1;
			p_s2[5] <= sx_s1 * cysz_s1;
			p_s2[6] <= cx_s1 * cysz_s1;
			p_s2[7] <= sx_s1 * sycz_s1;
		end
		if (rdy3 && v2_s2) begin
			q_s3 <= q_d;
		end
	end

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 && !out_ready |=> v3_s3 && $stable(q_s3))
		else $error("result dropped or changed under stall");

	// a filled middle stage moves on when the last stage is free
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && rdy3 |=> v3_s3)
		else $error("middle stage lost an item");

	// an empty first stage always takes input
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> in_ready)
		else $error("empty stage refused input");

endmodule
`default_nettype wire

### rtl/euler_to_quaternion.sv
// euler_to_quaternion: top level, zyx euler angles to unit quaternion.
// Depends on e2q_pkg, e2q_prep, e2q_cell and e2q_combine.
//
// Usage:
//   s_* carries one item of three angles in 1/64 degree units; m_* returns
//   the quaternion w, x, y, z in signed q(OUT_FRAC_BITS), 16 bits each.
//   The pipeline has one folding and scaling stage, one rotation cell per
//   cordic step and three combine stages. Throughput is one item per cycle
//   while m_tready is high; every stage is a register with its own valid
//   bit, so the rotation cells move items on whenever the next is free.
//   When m_tready is low the last stage holds its item and bubbles further
//   up are squeezed out before s_tready drops.
//   Reset clears all valid bits; the data registers are not reset.
//   Any 16-bit angle pattern gives the periodic result.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// angle_x_deg [15:0], angle_y_deg [31:16], angle_z_deg [47:32]
	input  wire logic [47:0]   s_tdata,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
	output logic [63:0]        m_tdata
);

	rot3_t chain_d [CORDIC_STEPS+1];
	logic  chain_v [CORDIC_STEPS+1];
	logic  chain_r [CORDIC_STEPS+1];

	// angle folding and radian scaling
	e2q_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (chain_v[0]),
		.out_ready (chain_r[0]),
		.out_data  (chain_d[0])
	);

	// row of rotation cells
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		e2q_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[i]),
			.in_ready  (chain_r[i]),
			.in_data   (chain_d[i]),
			.out_valid (chain_v[i+1]),
			.out_ready (chain_r[i+1]),
			.out_data  (chain_d[i+1])
		);
	end

	// quaternion product and output register
	e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_v[CORDIC_STEPS]),
		.in_ready  (chain_r[CORDIC_STEPS]),
		.in_data   (chain_d[CORDIC_STEPS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire
